FILE: sv/nst_pkg.sv
package nst_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH_DEF = 32;

    // fixed field widths
    localparam int ID_W    = 32;
    localparam int RSSI_W  = 12;
    localparam int TIME_W  = 32;
    localparam int PKT_W   = 32;
    localparam int RIDX_W  = 5;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    // stream widths: tdata filled up to whole bytes
    localparam int IN_FIELDS_W  = ID_W + RSSI_W + TIME_W + RIDX_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = 2;
    localparam int OUT_FIELDS_W = SLOT_W + COUNT_W + ID_W + 2 * RSSI_W + PKT_W + 2 * TIME_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 3;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_READ_OK  = 3'd3,
        STAT_READ_OOR = 3'd4,
        STAT_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } state_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ID_W-1:0]          node_id;
        logic signed [RSSI_W-1:0] last_rssi;
        logic signed [RSSI_W-1:0] best_rssi;
        logic [PKT_W-1:0]         packets;
        logic [TIME_W-1:0]        first_seen;
        logic [TIME_W-1:0]        last_seen;
    } entry_t;

endpackage

FILE: sv/node_stats_table.sv
// channel   | handshake                      | tdata (low bit up)                 | tuser
// ----------+--------------------------------+------------------------------------+-------
// s_axis    | s_axis_tvalid / s_axis_tready  | node_id, rssi, now_ms, read_index  | cmd
// m_axis    | m_axis_tvalid / m_axis_tready  | slot, entry_count, out_node_id,    | status
//           |                                | out_last_rssi, out_best_rssi,      |
//           |                                | out_packets, out_first_seen,       |
//           |                                | out_last_seen                      |
//
// an update searches for the id, reading one entry a cycle from the entry memory,
// then writes back the matched entry or a new one, unless the table is full
// a read is a registered memory read followed by the result; a clear goes via ST_DONE
// reset clears the entry count and control only; memory contents start undefined
// a new request is taken in idle, also while the previous result waits in the
// output register; a stalled output holds the block in its final state
module node_stats_table #(
    parameter int TABLE_DEPTH = nst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // node_id[31:0], rssi[43:32], now_ms[75:44], read_index[80:76], zero fill
    input  logic [nst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [nst_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot[4:0], entry_count[10:5], out_node_id[42:11], out_last_rssi[54:43],
    // out_best_rssi[66:55], out_packets[98:67], out_first_seen[130:99],
    // out_last_seen[162:131], zero fill
    output logic [nst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [nst_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    import nst_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // entry memory, one read and one write port
    entry_t mem [TABLE_DEPTH];

    state_t state_reg, state_next;

    // request fields
    cmd_t               cmd_reg;
    logic [ID_W-1:0]    node_id_reg;
    logic [RSSI_W-1:0]  rssi_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [RIDX_W-1:0]  ridx_reg;

    // table control
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_addr_reg, rd_addr_next;
    entry_t             rd_data_reg;

    // memory port controls
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    // result staging
    logic                 emit;
    logic                 can_emit;
    status_t              res_status;
    logic [IDX_W+4:0]     res_slot_src;
    logic [CNT_W+5:0]     res_cnt_src;
    entry_t               res_entry;
    status_t              out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    entry_t               out_entry_reg;
    logic                 out_valid_reg;

    // decoded input request
    cmd_t                 in_cmd;
    logic [RIDX_W-1:0]    in_ridx;
    logic [CNT_W+4:0]     in_ridx_wide;
    logic [CNT_W+4:0]     count_wide;
    logic                 in_range;

    // search and modify helpers
    logic                 hit;
    logic                 full;
    logic                 inserting;
    logic [CNT_W-1:0]     count_inc;
    entry_t               upd_entry;
    entry_t               new_entry;

    assign in_cmd       = cmd_t'(s_axis_tuser);
    assign in_ridx      = s_axis_tdata[80:76];
    assign in_ridx_wide = {{CNT_W{1'b0}}, in_ridx};
    assign count_wide   = {5'b0, count_reg};
    assign in_range     = in_ridx_wide < count_wide;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign can_emit      = !out_valid_reg || m_axis_tready;

    assign hit       = rd_valid_reg && (rd_data_reg.node_id == node_id_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign count_inc = count_reg + 1'b1;

    // matched entry after the update
    always_comb
    begin
        upd_entry           = rd_data_reg;
        upd_entry.last_rssi = rssi_reg;
        if ($signed(rssi_reg) > $signed(rd_data_reg.best_rssi))
        begin
            upd_entry.best_rssi = rssi_reg;
        end
        if (rd_data_reg.packets != {PKT_W{1'b1}})
        begin
            upd_entry.packets = rd_data_reg.packets + 1'b1;
        end
        upd_entry.last_seen = now_reg;
    end

    // fresh entry for a new id
    always_comb
    begin
        new_entry.node_id    = node_id_reg;
        new_entry.last_rssi  = rssi_reg;
        new_entry.best_rssi  = rssi_reg;
        new_entry.packets    = PKT_W'(1);
        new_entry.first_seen = now_reg;
        new_entry.last_seen  = now_reg;
    end

    // state register and table control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            rd_addr_reg  <= rd_addr_next;
        end
    end

    // capture the request on acceptance
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg     <= in_cmd;
            node_id_reg <= s_axis_tdata[31:0];
            rssi_reg    <= s_axis_tdata[43:32];
            now_reg     <= s_axis_tdata[75:44];
            ridx_reg    <= in_ridx;
        end
    end

    // next state, memory accesses and result selection
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_valid_next = rd_valid_reg;
        rd_addr_next  = rd_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = rd_addr_reg;
        wr_data       = upd_entry;
        inserting     = 1'b0;
        emit          = 1'b0;
        res_status    = STAT_UPDATED;
        res_slot_src  = '0;
        res_cnt_src   = {6'b0, count_reg};
        res_entry     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (in_cmd)
                        CMD_UPDATE:
                        begin
                            scan_next     = '0;
                            rd_valid_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        CMD_READ:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_ridx_wide[IDX_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    // matching id: write back the modified entry
                    if (can_emit)
                    begin
                        wr_en         = 1'b1;
                        emit          = 1'b1;
                        res_status    = STAT_UPDATED;
                        res_slot_src  = {5'b0, rd_addr_reg};
                        res_entry     = upd_entry;
                        rd_valid_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else if (scan_reg < count_reg)
                begin
                    // read the next entry, compared in the next cycle
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else if (can_emit)
                begin
                    // no match in the table
                    emit          = 1'b1;
                    rd_valid_next = 1'b0;
                    state_next    = ST_IDLE;
                    if (full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        inserting    = 1'b1;
                        wr_en        = 1'b1;
                        wr_addr      = count_reg[IDX_W-1:0];
                        wr_data      = new_entry;
                        count_next   = count_inc;
                        res_status   = STAT_INSERTED;
                        res_slot_src = {5'b0, count_reg[IDX_W-1:0]};
                        res_cnt_src  = {6'b0, count_inc};
                        res_entry    = new_entry;
                    end
                end
            end

            ST_READ:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    res_status   = STAT_READ_OK;
                    res_slot_src = {{IDX_W{1'b0}}, ridx_reg};
                    res_entry    = rd_data_reg;
                    state_next   = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        count_next  = '0;
                        res_status  = STAT_CLEARED;
                        res_cnt_src = '0;
                    end
                    else
                    begin
                        res_status   = STAT_READ_OOR;
                        res_slot_src = {{IDX_W{1'b0}}, ridx_reg};
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot_src[SLOT_W-1:0];
            out_count_reg  <= res_cnt_src[COUNT_W-1:0];
            out_entry_reg  <= res_entry;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {
        {(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
        out_entry_reg.last_seen,
        out_entry_reg.first_seen,
        out_entry_reg.packets,
        out_entry_reg.best_rssi,
        out_entry_reg.last_rssi,
        out_entry_reg.node_id,
        out_count_reg,
        out_slot_reg
    };

    // entry count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table size");

    // the single memory port pair is never read and written in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("memory read and write overlap");

    // an insert grows the table by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        inserting |=> count_reg == $past(count_inc))
        else $error("insert did not advance entry count");

    // a result is only staged when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || m_axis_tready))
        else $error("waiting result overwritten");

    // pending search data only exists during a search
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> state_reg == ST_SCAN)
        else $error("search read pending outside search");

endmodule
